FILE: src/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg: shared types and constants for the glyph code translator
// Character codes, glyph codes and the byte to glyph lookup function.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  // glyph codes with a special meaning
  localparam logic [7:0] GLYPH_INVALID = 8'd57;
  localparam logic [7:0] GLYPH_END     = 8'd63;

  // command characters that steer the raw modes
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] CHAR_GOTO     = 8'h40;

  // reset value of the goto argument count
  localparam logic [7:0] GOTO_ARG_RESET = 8'd2;

  // one translated result
  typedef struct packed {
    logic [7:0] out_code;
    logic       was_raw;
  } tgc_result_t;

  // byte to 6-bit glyph code, widened to a byte
  function automatic logic [7:0] glyph_code(input logic [7:0] c);
    logic [7:0] code;
    if (c >= 8'h61 && c <= 8'h7A) begin
      code = c - 8'h61;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      code = c - 8'h41;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      code = c - 8'd8;
    end else begin
      case (c)
        8'h30:    code = 8'd50;
        8'h2E:    code = 8'd26;
        8'h21:    code = 8'd27;
        8'h3F:    code = 8'd28;
        8'h2C:    code = 8'd29;
        8'h3B:    code = 8'd30;
        8'h27:    code = 8'd31;
        8'h22:    code = 8'd32;
        8'h20:    code = 8'd33;
        8'h5C:    code = 8'd34;
        8'h2F:    code = 8'd35;
        8'h28:    code = 8'd36;
        8'h29:    code = 8'd37;
        8'h3C:    code = 8'd38;
        8'h3E:    code = 8'd39;
        8'h3A:    code = 8'd40;
        8'h2A:    code = 8'd51;
        8'h2B:    code = 8'd52;
        8'h2D:    code = 8'd53;
        8'h3D:    code = 8'd54;
        8'h5E:    code = 8'd55;
        8'h26:    code = 8'd56;
        8'h23:    code = 8'd57;
        8'h24:    code = 8'd58;
        8'h5B:    code = 8'd59;
        8'h5D:    code = 8'd60;
        8'h0A:    code = 8'd61;
        8'h40:    code = 8'd62;
        8'h00:    code = GLYPH_END;
        default:  code = GLYPH_INVALID;
      endcase
    end
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: src/tgc_in_if.sv
// ----------------------------------------------------------------------------
// tgc_in_if: text byte request channel
// Valid/ready channel that carries one text byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

FILE: src/tgc_out_if.sv
// ----------------------------------------------------------------------------
// tgc_out_if: glyph code result channel
// Valid/ready channel that carries one output code and its raw flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_code;
  logic       was_raw;

  modport source (output valid, output out_code, output was_raw, input ready);
  modport sink   (input valid, input out_code, input was_raw, output ready);
endinterface

`default_nettype wire

FILE: src/text_to_glyph_code_translator_top.sv
// path: an accepted request goes through the input register and then the result register to code_out
// throughput: one request per cycle while code_out accepts results, set by the input and result registers
// the translation and mode update sit in one short logic stage between them
// reset: synchronous, clears both raw modes and the pipeline valid bits,
// and sets the goto argument count to 2
// ----------------------------------------------------------------------------
// text_to_glyph_code_translator_top: text byte to glyph code translator
// Input register, translation stage and result register with back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_glyph_code_translator_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  tgc_in_if.sink          text_in,
  tgc_out_if.source       code_out
);

  logic [7:0]           goto_arg;
  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 out_valid;
  tgc_pkg::tgc_result_t out_result;
  tgc_pkg::tgc_result_t xlate_result;
  logic                 out_free;
  logic                 advance;

  // pipeline flow control
  assign out_free      = !out_valid || code_out.ready;
  assign advance       = in_valid && out_free;
  assign text_in.ready = !in_valid || out_free;

  // goto argument count register
  always_ff @(posedge clk) begin
    if (rst) begin
      goto_arg <= tgc_pkg::GOTO_ARG_RESET;
    end else if (cfg_wr_en) begin
      goto_arg <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_in.ready) begin
      in_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      in_byte <= text_in.text_byte;
    end
  end

  tgc_xlate u_xlate (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .text_byte      (in_byte),
    .goto_arg_bytes (goto_arg),
    .result         (xlate_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= xlate_result;
    end
  end

  assign code_out.valid    = out_valid;
  assign code_out.out_code = out_result.out_code;
  assign code_out.was_raw  = out_result.was_raw;

endmodule

`default_nettype wire

FILE: src/tgc_xlate.sv
// ----------------------------------------------------------------------------
// tgc_xlate: mode tracking and byte translation
// Holds the bracket and goto raw modes and translates one byte per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_xlate (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [7:0]        text_byte,
  input  wire logic [7:0]        goto_arg_bytes,
  output tgc_pkg::tgc_result_t   result
);

  logic       bracket_mode;
  logic       bracket_mode_next;
  logic [7:0] raw_bytes_left;
  logic [7:0] raw_bytes_left_next;
  logic       count_active;
  logic [7:0] glyph;

  assign count_active = (raw_bytes_left != 8'd0);
  assign glyph        = tgc_pkg::glyph_code(text_byte);

  // translate and work out the next mode
  always_comb begin
    bracket_mode_next   = bracket_mode;
    raw_bytes_left_next = raw_bytes_left;
    result.out_code     = glyph;
    result.was_raw      = 1'b0;
    if (count_active || bracket_mode) begin
      if (count_active) begin
        raw_bytes_left_next = raw_bytes_left - 8'd1;
      end
      if (bracket_mode && text_byte == tgc_pkg::CHAR_RBRACKET) begin
        bracket_mode_next = 1'b0;
      end else begin
        result.out_code = text_byte;
        result.was_raw  = 1'b1;
      end
    end else if (text_byte == tgc_pkg::CHAR_LBRACKET) begin
      bracket_mode_next = 1'b1;
    end else if (text_byte == tgc_pkg::CHAR_GOTO) begin
      raw_bytes_left_next = goto_arg_bytes;
    end
    // end of string clears both modes
    if (text_byte == tgc_pkg::CHAR_NUL) begin
      bracket_mode_next   = 1'b0;
      raw_bytes_left_next = 8'd0;
    end
  end

  // mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      bracket_mode   <= 1'b0;
      raw_bytes_left <= 8'd0;
    end else if (advance) begin
      bracket_mode   <= bracket_mode_next;
      raw_bytes_left <= raw_bytes_left_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the glyph code translator
// Drives text bytes over the request channel with random gaps, predicts each
// glyph code and raw flag from a local copy of the translator state, and
// checks every result in order. A short table of known cases comes first,
// then random text runs under several goto argument counts.
// ----------------------------------------------------------------------------
module tb_top;
  import tgc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int PHASE_ITEMS     = 265;
  localparam int NUM_PHASES      = 6;
  localparam int DIRECTED_ROWS   = 25;

  // directed stimulus row, expectation given only where known is set
  typedef struct {
    logic [7:0] ch;
    bit         known;
    logic [7:0] code;
    bit         raw;
  } glyph_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  tgc_in_if  text_in_ch ();
  tgc_out_if code_out_ch ();

  text_to_glyph_code_translator_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .text_in     (text_in_ch),
    .code_out    (code_out_ch)
  );

  // translator state as the bench expects it
  logic [7:0]  pred_goto_count;
  logic        pred_in_bracket;
  logic [7:0]  pred_raw_left;
  tgc_result_t expected_glyphs [$];
  tgc_result_t glyph_want;

  int error_count;
  int bytes_sent;
  int codes_checked;
  int raw_seen;
  int goto_writes;
  int idle_cycles;
  bit hold_off_req;
  bit gap_free;
  int goto_plan [NUM_PHASES];

  glyph_row_t directed_rows [DIRECTED_ROWS] = '{
    '{"a", 1'b1, 8'd0, 1'b0},
    '{"z", 1'b1, 8'd25, 1'b0},
    '{"A", 1'b1, 8'd0, 1'b0},
    '{"Z", 1'b1, 8'd25, 1'b0},
    '{"1", 1'b1, 8'd41, 1'b0},
    '{"9", 1'b1, 8'd49, 1'b0},
    '{"0", 1'b1, 8'd50, 1'b0},
    '{8'hFF, 1'b1, GLYPH_INVALID, 1'b0},
    '{8'h80, 1'b1, GLYPH_INVALID, 1'b0},
    '{"?", 1'b0, 8'd0, 1'b0},
    '{"$", 1'b1, 8'd58, 1'b0},
    '{"\n", 1'b1, 8'd61, 1'b0},
    '{CHAR_NUL, 1'b1, GLYPH_END, 1'b0},
    // bracket mode: goto byte inside passes raw, close is translated
    '{CHAR_LBRACKET, 1'b1, 8'd59, 1'b0},
    '{CHAR_GOTO, 1'b1, CHAR_GOTO, 1'b1},
    '{CHAR_RBRACKET, 1'b1, 8'd60, 1'b0},
    // goto with the reset count of two, nul while raw clears the count
    '{CHAR_GOTO, 1'b1, 8'd62, 1'b0},
    '{CHAR_LBRACKET, 1'b1, CHAR_LBRACKET, 1'b1},
    '{CHAR_NUL, 1'b1, CHAR_NUL, 1'b1},
    '{"b", 1'b1, 8'd1, 1'b0},
    // nul inside brackets ends bracket mode
    '{CHAR_LBRACKET, 1'b1, 8'd59, 1'b0},
    '{CHAR_NUL, 1'b1, CHAR_NUL, 1'b1},
    '{CHAR_RBRACKET, 1'b1, 8'd60, 1'b0},
    '{"~", 1'b0, 8'd0, 1'b0},
    '{"^", 1'b0, 8'd0, 1'b0}
  };

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // byte to glyph code in normal mode
  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    string punct_set = ".!?,;'\" \\/()<>:";
    string symbol_set = "*+-=^&#$[]\n@";
    if (c >= "a" && c <= "z") return c - "a";
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "1" && c <= "9") return c - 8'd8;
    if (c == "0") return 8'd50;
    if (c == CHAR_NUL) return GLYPH_END;
    for (int i = 0; i < punct_set.len(); i++) begin
      if (c == punct_set[i]) return 8'(26 + i);
    end
    for (int i = 0; i < symbol_set.len(); i++) begin
      if (c == symbol_set[i]) return 8'(51 + i);
    end
    return GLYPH_INVALID;
  endfunction

  // expected result of one text byte, advances the mode state
  function automatic tgc_result_t predict_glyph(input logic [7:0] c);
    tgc_result_t res;
    if (pred_raw_left != 8'd0 || pred_in_bracket) begin
      if (pred_raw_left != 8'd0) pred_raw_left = pred_raw_left - 8'd1;
      if (pred_in_bracket && c == CHAR_RBRACKET) begin
        pred_in_bracket = 1'b0;
        res = '{glyph_of(c), 1'b0};
      end else begin
        res = '{c, 1'b1};
      end
    end else begin
      if (c == CHAR_LBRACKET) pred_in_bracket = 1'b1;
      else if (c == CHAR_GOTO) pred_raw_left = pred_goto_count;
      res = '{glyph_of(c), 1'b0};
    end
    // end of string drops both modes
    if (c == CHAR_NUL) begin
      pred_in_bracket = 1'b0;
      pred_raw_left = 8'd0;
    end
    return res;
  endfunction

  // idle length, mostly short with a few long ones
  function automatic int pick_gap();
    int r;
    if (gap_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // printable or newline text byte with no mode meaning
  function automatic logic [7:0] pick_plain_byte();
    string pool = ".!?,;'\" \\/()<>:*+-=^&#$\n";
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'("a" + $urandom_range(0, 25));
    if (r < 6) return 8'("A" + $urandom_range(0, 25));
    if (r < 8) return 8'("0" + $urandom_range(0, 9));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // offer one request and record its expected result on acceptance
  task automatic send_byte(input logic [7:0] c, input bit known = 1'b0,
                           input tgc_result_t want = '0);
    int gap;
    tgc_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      text_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    text_in_ch.valid <= 1'b1;
    text_in_ch.text_byte <= c;
    do @(posedge clk); while (!(text_in_ch.valid && text_in_ch.ready));
    predicted = predict_glyph(c);
    expected_glyphs.push_back(known ? want : predicted);
    bytes_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_for_drain();
    @(negedge clk);
    text_in_ch.valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // goto count write while the block is idle
  task automatic write_goto_count(input logic [7:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pred_goto_count = value;
    goto_writes++;
  endtask

  // one random run of text: words, bracket groups, goto commands, ends, noise
  task automatic send_text_run();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(pick_plain_byte());
    end else if (r < 55) begin
      send_byte(CHAR_LBRACKET);
      n = $urandom_range(0, 10);
      repeat (n) send_byte($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255))
                                                     : pick_plain_byte());
      send_byte(CHAR_RBRACKET);
    end else if (r < 70) begin
      send_byte(CHAR_GOTO);
      n = $urandom_range(0, pred_goto_count > 12 ? 12 : pred_goto_count);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else if (r < 80) begin
      send_byte(CHAR_NUL);
    end else if (r < 88) begin
      send_byte($urandom_range(0, 1) ? CHAR_GOTO : CHAR_LBRACKET);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result side ready with random stalls and an occasional long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    code_out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        code_out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        code_out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        code_out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        code_out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && code_out_ch.valid && code_out_ch.ready) begin
      if (expected_glyphs.size() == 0) begin
        $error("out_code: no request waiting, got %0d (was_raw %0b)",
               code_out_ch.out_code, code_out_ch.was_raw);
        error_count++;
      end else begin
        glyph_want = expected_glyphs.pop_front();
        if (code_out_ch.out_code !== glyph_want.out_code) begin
          $error("out_code: expected %0d, got %0d", glyph_want.out_code,
                 code_out_ch.out_code);
          error_count++;
        end
        if (code_out_ch.was_raw !== glyph_want.was_raw) begin
          $error("was_raw: expected %0b, got %0b", glyph_want.was_raw,
                 code_out_ch.was_raw);
          error_count++;
        end
      end
      codes_checked++;
      if (code_out_ch.was_raw === 1'b1) raw_seen++;
    end
  end

  // watchdog on cycles where no request moves on either side
  always @(posedge clk) begin
    if (rst || (text_in_ch.valid && text_in_ch.ready) ||
        (code_out_ch.valid && code_out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    int phase_start;
    bit held;
    bit paused;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    text_in_ch.valid = 1'b0;
    text_in_ch.text_byte = 8'd0;
    pred_goto_count = GOTO_ARG_RESET;
    pred_in_bracket = 1'b0;
    pred_raw_left = 8'd0;
    error_count = 0;
    bytes_sent = 0;
    codes_checked = 0;
    raw_seen = 0;
    goto_writes = 0;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    gap_free = 1'b0;
    goto_plan = '{0, 255, 1, 0, 2, 128};
    goto_plan[3] = $urandom_range(3, 20);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // known cases from reset
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].ch, directed_rows[i].known,
                '{directed_rows[i].code, directed_rows[i].raw});
    end

    // random text under each goto count
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_goto_count(8'(goto_plan[p]));
      gap_free = (p == 3);
      phase_start = bytes_sent;
      held = 1'b0;
      paused = 1'b0;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        // long result stall while requests keep coming
        if (!held && bytes_sent - phase_start >= 40) begin
          hold_off_req = 1'b1;
          held = 1'b1;
        end
        // sender pause until every result is back
        if (!paused && bytes_sent - phase_start >= 150) begin
          wait_for_drain();
          paused = 1'b1;
        end
        send_text_run();
      end
    end

    wait_for_drain();
    $display("%0d text bytes sent, %0d glyph codes checked, %0d of them raw",
             bytes_sent, codes_checked, raw_seen);
    $display("goto count written %0d times, including 0 and 255", goto_writes);
    if (error_count == 0 && expected_glyphs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
